// ===== hw/rtl/nmb_pkg.sv =====
// ----------------------------------------------------------------------------
// nmb_pkg
// Shared constants for the normal matrix builder: fixed-point format,
// threshold register layout and the cofactor product index tables.
// ----------------------------------------------------------------------------
package nmb_pkg;

    localparam int FRAC_BITS  = 24;
    localparam int NUM_ELEM   = 9;
    localparam int THR_WIDTH  = 32;
    localparam int THR_SHIFT  = 3 * FRAC_BITS - 48;
    localparam int LIM_WIDTH  = THR_WIDTH + THR_SHIFT;
    localparam logic [THR_WIDTH-1:0] THR_RESET = 32'd2814750;

    // cofactor(l) = a[CF_PA[l]] * a[CF_PB[l]] - a[CF_SA[l]] * a[CF_SB[l]]
    localparam int CF_PA [NUM_ELEM] = '{4, 5, 3, 2, 0, 1, 1, 2, 0};
    localparam int CF_PB [NUM_ELEM] = '{8, 6, 7, 7, 8, 6, 5, 3, 4};
    localparam int CF_SA [NUM_ELEM] = '{5, 3, 4, 1, 2, 0, 2, 0, 1};
    localparam int CF_SB [NUM_ELEM] = '{7, 8, 6, 8, 6, 7, 4, 5, 3};

endpackage

// ===== hw/rtl/nmb_cofactor.sv =====
// ----------------------------------------------------------------------------
// nmb_cofactor
// Two stages: eighteen element products, then the nine signed cofactors.
// ----------------------------------------------------------------------------
module nmb_cofactor
    import nmb_pkg::*;
#(
    parameter int ELEM_WIDTH = 32
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [NUM_ELEM*ELEM_WIDTH-1:0]     in_elem,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [NUM_ELEM*(2*ELEM_WIDTH+1)-1:0] out_cf,
    output logic [3*ELEM_WIDTH-1:0]            out_row0
);

    localparam int W  = ELEM_WIDTH;
    localparam int PW = 2 * W;
    localparam int CW = 2 * W + 1;

    logic signed [W-1:0]  a [NUM_ELEM];
    logic signed [PW-1:0] prod_p_next [NUM_ELEM];
    logic signed [PW-1:0] prod_s_next [NUM_ELEM];
    logic signed [PW-1:0] prod_p_reg  [NUM_ELEM];
    logic signed [PW-1:0] prod_s_reg  [NUM_ELEM];
    logic signed [CW-1:0] cf_next [NUM_ELEM];
    logic signed [CW-1:0] cf_reg  [NUM_ELEM];
    logic [3*W-1:0]       row0_a_reg;
    logic [3*W-1:0]       row0_b_reg;
    logic                 va_reg;
    logic                 vb_reg;
    logic                 rdy_a;
    logic                 rdy_b;

    assign rdy_b    = !vb_reg || out_ready;
    assign rdy_a    = !va_reg || rdy_b;
    assign in_ready = rdy_a;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else
        begin
            if (rdy_a)
            begin
                va_reg <= in_valid;
            end
            if (rdy_b)
            begin
                vb_reg <= va_reg;
            end
        end
    end

    for (genvar l = 0; l < NUM_ELEM; l++)
    begin : g_lane
        assign a[l]           = in_elem[l*W +: W];
        assign prod_p_next[l] = a[CF_PA[l]] * a[CF_PB[l]];
        assign prod_s_next[l] = a[CF_SA[l]] * a[CF_SB[l]];
        assign cf_next[l]     = $signed({prod_p_reg[l][PW-1], prod_p_reg[l]})
                              - $signed({prod_s_reg[l][PW-1], prod_s_reg[l]});
        assign out_cf[l*CW +: CW] = cf_reg[l];
    end

    always_ff @(posedge clk)
    begin
        if (rdy_a)
        begin
            prod_p_reg <= prod_p_next;
            prod_s_reg <= prod_s_next;
            row0_a_reg <= in_elem[3*W-1:0];
        end
        if (rdy_b)
        begin
            cf_reg     <= cf_next;
            row0_b_reg <= row0_a_reg;
        end
    end

    assign out_valid = vb_reg;
    assign out_row0  = row0_b_reg;

endmodule

// ===== hw/rtl/nmb_det.sv =====
// ----------------------------------------------------------------------------
// nmb_det
// Five stages: magnitudes, split partial products, signed terms, sum,
// determinant magnitude. Cofactor magnitudes and signs ride along.
// ----------------------------------------------------------------------------
module nmb_det
    import nmb_pkg::*;
#(
    parameter int ELEM_WIDTH = 32
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [NUM_ELEM*(2*ELEM_WIDTH+1)-1:0] in_cf,
    input  logic [3*ELEM_WIDTH-1:0]              in_row0,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [NUM_ELEM*2*ELEM_WIDTH-1:0]     out_cm,
    output logic [NUM_ELEM-1:0]                  out_cs,
    output logic [3*ELEM_WIDTH-1:0]              out_dabs,
    output logic                                 out_dneg
);

    localparam int W  = ELEM_WIDTH;
    localparam int CW = 2 * W + 1;
    localparam int CM = 2 * W;
    localparam int TM = 3 * W;
    localparam int DW = 3 * W + 1;
    localparam int NS = 5;

    logic [NS-1:0] v_reg;
    logic [NS-1:0] rdy;

    logic signed [CW-1:0] cf [NUM_ELEM];
    logic signed [W-1:0]  a  [3];

    // stage C: magnitudes
    logic [W-1:0]  am_next [3];
    logic [W-1:0]  am_reg  [3];
    logic [2:0]    as_next;
    logic [2:0]    as_reg;
    logic [CM-1:0] cm_next [NUM_ELEM];
    logic [CM-1:0] cm_c_reg [NUM_ELEM];
    logic [NUM_ELEM-1:0] cs_next;
    logic [NUM_ELEM-1:0] cs_c_reg;
    // stage D: partial products
    logic [CM-1:0] plo_next [3];
    logic [CM-1:0] phi_next [3];
    logic [CM-1:0] plo_reg  [3];
    logic [CM-1:0] phi_reg  [3];
    logic [2:0]    ts_next;
    logic [2:0]    ts_reg;
    logic [CM-1:0] cm_d_reg [NUM_ELEM];
    logic [NUM_ELEM-1:0] cs_d_reg;
    // stage E: signed terms
    logic [TM-1:0]        mag [3];
    logic signed [DW-1:0] term_next [3];
    logic signed [DW-1:0] term_reg  [3];
    logic [CM-1:0] cm_e_reg [NUM_ELEM];
    logic [NUM_ELEM-1:0] cs_e_reg;
    // stage F: determinant
    logic signed [DW-1:0] det_next;
    logic signed [DW-1:0] det_reg;
    logic [CM-1:0] cm_f_reg [NUM_ELEM];
    logic [NUM_ELEM-1:0] cs_f_reg;
    // stage G: magnitude of determinant
    logic [TM-1:0] dabs_next;
    logic [TM-1:0] dabs_reg;
    logic          dneg_reg;
    logic [CM-1:0] cm_g_reg [NUM_ELEM];
    logic [NUM_ELEM-1:0] cs_g_reg;

    for (genvar s = 0; s < NS; s++)
    begin : g_rdy
        if (s == NS - 1)
        begin : g_last
            assign rdy[s] = !v_reg[s] || out_ready;
        end
        else
        begin : g_mid
            assign rdy[s] = !v_reg[s] || rdy[s+1];
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = v_reg[NS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            for (int s = 0; s < NS; s++)
            begin
                if (rdy[s])
                begin
                    v_reg[s] <= (s == 0) ? in_valid : v_reg[s-1];
                end
            end
        end
    end

    for (genvar l = 0; l < NUM_ELEM; l++)
    begin : g_cf
        assign cf[l]      = in_cf[l*CW +: CW];
        assign cm_next[l] = CM'(cf[l][CW-1] ? -cf[l] : cf[l]);
        assign cs_next[l] = cf[l][CW-1];
        assign out_cm[l*CM +: CM] = cm_g_reg[l];
    end

    for (genvar t = 0; t < 3; t++)
    begin : g_term
        assign a[t]         = in_row0[t*W +: W];
        assign am_next[t]   = W'(a[t][W-1] ? -a[t] : a[t]);
        assign as_next[t]   = a[t][W-1];
        assign plo_next[t]  = CM'(am_reg[t]) * CM'(cm_c_reg[t][W-1:0]);
        assign phi_next[t]  = CM'(am_reg[t]) * CM'(cm_c_reg[t][CM-1:W]);
        assign ts_next[t]   = as_reg[t] ^ cs_c_reg[t];
        assign mag[t]       = TM'(plo_reg[t]) + (TM'(phi_reg[t]) << W);
        assign term_next[t] = ts_reg[t] ? -$signed({1'b0, mag[t]}) : $signed({1'b0, mag[t]});
    end

    assign det_next  = term_reg[0] + term_reg[1] + term_reg[2];
    assign dabs_next = TM'(det_reg[DW-1] ? -det_reg : det_reg);

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            am_reg   <= am_next;
            as_reg   <= as_next;
            cm_c_reg <= cm_next;
            cs_c_reg <= cs_next;
        end
        if (rdy[1])
        begin
            plo_reg  <= plo_next;
            phi_reg  <= phi_next;
            ts_reg   <= ts_next;
            cm_d_reg <= cm_c_reg;
            cs_d_reg <= cs_c_reg;
        end
        if (rdy[2])
        begin
            term_reg <= term_next;
            cm_e_reg <= cm_d_reg;
            cs_e_reg <= cs_d_reg;
        end
        if (rdy[3])
        begin
            det_reg  <= det_next;
            cm_f_reg <= cm_e_reg;
            cs_f_reg <= cs_e_reg;
        end
        if (rdy[4])
        begin
            dabs_reg <= dabs_next;
            dneg_reg <= det_reg[DW-1];
            cm_g_reg <= cm_f_reg;
            cs_g_reg <= cs_f_reg;
        end
    end

    assign out_cs   = cs_g_reg;
    assign out_dabs = dabs_reg;
    assign out_dneg = dneg_reg;

endmodule

// ===== hw/rtl/nmb_divider.sv =====
// ----------------------------------------------------------------------------
// nmb_divider
// Singular and overflow checks, then a restoring divider with one quotient
// bit per stage for all nine lanes, then saturation and sign.
// ----------------------------------------------------------------------------
module nmb_divider
    import nmb_pkg::*;
#(
    parameter int ELEM_WIDTH = 32
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [NUM_ELEM*2*ELEM_WIDTH-1:0] in_cm,
    input  logic [NUM_ELEM-1:0]              in_cs,
    input  logic [3*ELEM_WIDTH-1:0]          in_dabs,
    input  logic                             in_dneg,
    input  logic [THR_WIDTH-1:0]             thr,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [NUM_ELEM*ELEM_WIDTH-1:0]   out_n,
    output logic                             out_singular
);

    localparam int W    = ELEM_WIDTH;
    localparam int CM   = 2 * W;
    localparam int DM   = 3 * W;
    localparam int NW   = CM + 2 * FRAC_BITS;
    localparam int XW   = (NW > DM + W) ? NW : DM + W;
    localparam int CMPW = (DM > LIM_WIDTH) ? DM : LIM_WIDTH;
    localparam int NS   = W + 2;

    localparam logic [W-1:0] MAXP = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MAXN = {1'b1, {(W-1){1'b0}}};

    logic [NS-1:0] v_reg;
    logic [NS-1:0] rdy;

    // stage 0 is the check stage, stages 1..W each settle one quotient bit;
    // remainder and divisor are carried only as far as the last stage needs
    logic [NW-1:0]       rem_reg  [W][NUM_ELEM];
    logic [W-1:0]        q_reg    [W][NUM_ELEM];
    logic [DM-1:0]       d_reg    [W];
    logic [NUM_ELEM-1:0] neg_reg  [W+1];
    logic [NUM_ELEM-1:0] ovf_reg  [W+1];
    logic                sing_reg [W+1];

    logic [NW-1:0]       num_next [NUM_ELEM];
    logic [NUM_ELEM-1:0] ovf_next;
    logic                sing_next;

    logic [W-1:0]        n_next [NUM_ELEM];
    logic [W-1:0]        n_reg  [NUM_ELEM];
    logic                sing_out_reg;

    for (genvar s = 0; s < NS; s++)
    begin : g_rdy
        if (s == NS - 1)
        begin : g_last
            assign rdy[s] = !v_reg[s] || out_ready;
        end
        else
        begin : g_mid
            assign rdy[s] = !v_reg[s] || rdy[s+1];
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = v_reg[NS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            for (int s = 0; s < NS; s++)
            begin
                if (rdy[s])
                begin
                    v_reg[s] <= (s == 0) ? in_valid : v_reg[s-1];
                end
            end
        end
    end

    // check stage
    assign sing_next = (in_dabs == '0)
                    || (CMPW'(in_dabs) < (CMPW'(thr) << THR_SHIFT));

    for (genvar l = 0; l < NUM_ELEM; l++)
    begin : g_chk
        assign num_next[l] = NW'(in_cm[l*CM +: CM]) << (2 * FRAC_BITS);
        assign ovf_next[l] = XW'(num_next[l]) >= (XW'(in_dabs) << W);
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            rem_reg[0]  <= num_next;
            d_reg[0]    <= in_dabs;
            neg_reg[0]  <= in_cs ^ {NUM_ELEM{in_dneg}};
            ovf_reg[0]  <= ovf_next;
            sing_reg[0] <= sing_next;
        end
    end

    // division stages
    for (genvar s = 1; s <= W; s++)
    begin : g_div
        logic [XW-1:0]       dsh;
        logic [XW-1:0]       rx     [NUM_ELEM];
        logic [NUM_ELEM-1:0] ge;
        logic [W-1:0]        q_next [NUM_ELEM];

        assign dsh = XW'(d_reg[s-1]) << (W - s);

        for (genvar l = 0; l < NUM_ELEM; l++)
        begin : g_lane
            logic [W-1:0] q_prev;

            assign rx[l] = XW'(rem_reg[s-1][l]);
            assign ge[l] = rx[l] >= dsh;
            if (s == 1)
            begin : g_first
                assign q_prev = '0;
            end
            else
            begin : g_rest
                assign q_prev = q_reg[s-2][l];
            end
            assign q_next[l] = q_prev | (W'(ge[l]) << (W - s));
        end

        always_ff @(posedge clk)
        begin
            if (rdy[s])
            begin
                q_reg[s-1]  <= q_next;
                neg_reg[s]  <= neg_reg[s-1];
                ovf_reg[s]  <= ovf_reg[s-1];
                sing_reg[s] <= sing_reg[s-1];
            end
        end

        // advance remainder and divisor to every stage but the last
        if (s < W)
        begin : g_carry
            logic [NW-1:0] rem_next [NUM_ELEM];

            for (genvar l = 0; l < NUM_ELEM; l++)
            begin : g_lane
                assign rem_next[l] = ge[l] ? NW'(rx[l] - dsh) : rem_reg[s-1][l];
            end

            always_ff @(posedge clk)
            begin
                if (rdy[s])
                begin
                    rem_reg[s] <= rem_next;
                    d_reg[s]   <= d_reg[s-1];
                end
            end
        end
    end

    // saturate, apply sign, zero a singular matrix
    for (genvar l = 0; l < NUM_ELEM; l++)
    begin : g_out
        logic [W-1:0] q;
        assign q = q_reg[W-1][l];
        always_comb
        begin
            if (sing_reg[W])
            begin
                n_next[l] = '0;
            end
            else if (neg_reg[W][l])
            begin
                n_next[l] = (ovf_reg[W][l] || (q > MAXN)) ? MAXN : -q;
            end
            else
            begin
                n_next[l] = (ovf_reg[W][l] || q[W-1]) ? MAXP : q;
            end
        end
        assign out_n[l*W +: W] = n_reg[l];
    end

    always_ff @(posedge clk)
    begin
        if (rdy[NS-1])
        begin
            n_reg        <= n_next;
            sing_out_reg <= sing_reg[W];
        end
    end

    assign out_singular = sing_out_reg;

endmodule

// ===== hw/rtl/normal_matrix_builder.sv =====
// ----------------------------------------------------------------------------
// normal_matrix_builder
// Throughput: one matrix per cycle while m_tready is high; the
// restoring divider settles one quotient bit per stage in all nine
// lanes, which sets the pipeline depth.
// Reset clears every stage valid and loads the threshold register with 2814750.
// ----------------------------------------------------------------------------
//
// Inverse transpose of a 3x3 in signed fixed point (24 fraction bits).
// Pipeline:
//   cofactor  - 2 stages: element products, nine cofactors
//   det       - 5 stages: magnitudes, split partial products, signed terms,
//               determinant sum, determinant magnitude
//   divider   - check stage (singular, quotient overflow), ELEM_WIDTH
//               restoring stages, saturation/sign output register
// Each stage holds its own valid and advances when the next one has room,
// so bubbles collapse and input keeps flowing while a result waits.
module normal_matrix_builder
    import nmb_pkg::*;
#(
    parameter int ELEM_WIDTH = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // m00 m01 m02 m10 m11 m12 m20 m21 m22, ELEM_WIDTH each, from bit 0 up
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [((NUM_ELEM*ELEM_WIDTH+7)/8)*8-1:0] s_tdata,
    // n00 n01 n02 n10 n11 n12 n20 n21 n22, ELEM_WIDTH each, from bit 0 up
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [((NUM_ELEM*ELEM_WIDTH+7)/8)*8-1:0] m_tdata,
    // singular
    output logic [0:0]           m_tuser,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [THR_WIDTH-1:0] cfg_data
);

    localparam int W      = ELEM_WIDTH;
    localparam int CW     = 2 * W + 1;
    localparam int CM     = 2 * W;
    localparam int DATA_W = ((NUM_ELEM * W + 7) / 8) * 8;

    logic [THR_WIDTH-1:0] thr_reg;

    logic                      cof_valid;
    logic                      cof_ready;
    logic [NUM_ELEM*CW-1:0]    cof_cf;
    logic [3*W-1:0]            cof_row0;

    logic                      det_valid;
    logic                      det_ready;
    logic [NUM_ELEM*CM-1:0]    det_cm;
    logic [NUM_ELEM-1:0]       det_cs;
    logic [3*W-1:0]            det_dabs;
    logic                      det_dneg;

    logic [NUM_ELEM*W-1:0]     div_n;
    logic                      div_singular;

    // threshold register: always ready, written on each transfer
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THR_RESET;
        end
        else if (cfg_valid)
        begin
            thr_reg <= cfg_data;
        end
    end

    nmb_cofactor #(
        .ELEM_WIDTH (W)
    ) u_cofactor (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_elem   (s_tdata[NUM_ELEM*W-1:0]),
        .out_valid (cof_valid),
        .out_ready (cof_ready),
        .out_cf    (cof_cf),
        .out_row0  (cof_row0)
    );

    nmb_det #(
        .ELEM_WIDTH (W)
    ) u_det (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cof_valid),
        .in_ready  (cof_ready),
        .in_cf     (cof_cf),
        .in_row0   (cof_row0),
        .out_valid (det_valid),
        .out_ready (det_ready),
        .out_cm    (det_cm),
        .out_cs    (det_cs),
        .out_dabs  (det_dabs),
        .out_dneg  (det_dneg)
    );

    nmb_divider #(
        .ELEM_WIDTH (W)
    ) u_divider (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (det_valid),
        .in_ready     (det_ready),
        .in_cm        (det_cm),
        .in_cs        (det_cs),
        .in_dabs      (det_dabs),
        .in_dneg      (det_dneg),
        .thr          (thr_reg),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_n        (div_n),
        .out_singular (div_singular)
    );

    // pad the packed elements with zeros up to whole bytes
    assign m_tdata    = DATA_W'(div_n);
    assign m_tuser[0] = div_singular;

endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for normal_matrix_builder: streams 3x3 matrices with
// random idling on both sides, predicts each inverse transpose at full
// precision and compares every result transfer field by field.
// ----------------------------------------------------------------------------
module testbench
    import nmb_pkg::*;
();

    localparam int EW      = 32;
    localparam int DW      = ((NUM_ELEM * EW + 7) / 8) * 8;
    localparam int LATENCY = EW + 9;
    localparam int NRAND   = 530;
    localparam int NDIR    = 14;

    typedef logic signed [EW-1:0] elem_t;
    typedef elem_t mat_t [NUM_ELEM];

    typedef struct {
        logic [DW-1:0] data;
        logic          sing;
    } normal_t;

    logic            clk;
    logic            rst_n;
    logic            s_tvalid;
    logic            s_tready;
    logic [DW-1:0]   s_tdata;
    logic            m_tvalid;
    logic            m_tready;
    logic [DW-1:0]   m_tdata;
    logic [0:0]      m_tuser;
    logic            cfg_valid;
    logic            cfg_ready;
    logic [THR_WIDTH-1:0] cfg_data;

    logic [THR_WIDTH-1:0] threshold;
    normal_t              pending_normals [$];
    int                   errors;
    bit                   quiet;
    bit                   sink_on;

    normal_matrix_builder #(.ELEM_WIDTH(EW)) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #50000000;
        $display("TB_ERROR");
        $finish;
    end

    // Inverse transpose at full precision: products of three Q8.24 values fit
    // in 96 bits signed, so 256-bit arithmetic leaves plenty of headroom.
    function automatic normal_t predict_normal(input mat_t m);
        logic signed [255:0] a [NUM_ELEM];
        logic signed [255:0] cof [NUM_ELEM];
        logic signed [255:0] det;
        logic [255:0]        dmag;
        logic [255:0]        num;
        logic [255:0]        quo;
        logic [255:0]        lim;
        logic [255:0]        maxp;
        logic [EW-1:0]       res;
        bit                  neg;
        normal_t             r;
        r.data = '0;
        for (int i = 0; i < NUM_ELEM; i++)
            a[i] = m[i];
        cof[0] = a[4] * a[8] - a[5] * a[7];
        cof[1] = a[5] * a[6] - a[3] * a[8];
        cof[2] = a[3] * a[7] - a[4] * a[6];
        cof[3] = a[2] * a[7] - a[1] * a[8];
        cof[4] = a[0] * a[8] - a[2] * a[6];
        cof[5] = a[1] * a[6] - a[0] * a[7];
        cof[6] = a[1] * a[5] - a[2] * a[4];
        cof[7] = a[2] * a[3] - a[0] * a[5];
        cof[8] = a[0] * a[4] - a[1] * a[3];
        det  = a[0] * cof[0] + a[1] * cof[1] + a[2] * cof[2];
        dmag = det < 0 ? -det : det;
        // det carries 72 fraction bits, the threshold 48
        lim  = 256'(threshold) << (3 * FRAC_BITS - 48);
        if (dmag == 0 || dmag < lim)
        begin
            r.sing = 1'b1;
            return r;
        end
        r.sing = 1'b0;
        maxp = (256'd1 << (EW - 1)) - 1;
        for (int i = 0; i < NUM_ELEM; i++)
        begin
            neg = (cof[i] < 0) != (det < 0);
            num = (cof[i] < 0 ? -cof[i] : cof[i]);
            num = num << (2 * FRAC_BITS);
            quo = num / dmag;
            if (!neg && quo > maxp)
                quo = maxp;
            if (neg && quo > maxp + 1)
                quo = maxp + 1;
            res = quo[EW-1:0];
            if (neg)
                res = -res;
            r.data[i*EW +: EW] = res;
        end
        return r;
    endfunction

    function automatic logic [DW-1:0] pack_matrix(input mat_t m);
        logic [DW-1:0] d;
        d = '0;
        for (int i = 0; i < NUM_ELEM; i++)
            d[i*EW +: EW] = m[i];
        return d;
    endfunction

    function automatic elem_t rand_elem();
        case ($urandom_range(0, 5))
            0: return elem_t'($urandom);
            1: return elem_t'(32'h8000_0000 | $urandom_range(0, 3));
            2: return elem_t'(32'h7FFF_FFFF - $urandom_range(0, 3));
            3: return elem_t'($signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000);
            default: return elem_t'($signed($urandom_range(0, 32'h0040_0000))
                                     - 32'sh0020_0000);
        endcase
    endfunction

    // Random matrix, sometimes near-diagonal and sometimes rank deficient
    function automatic mat_t rand_matrix();
        mat_t m;
        int   k;
        for (int i = 0; i < NUM_ELEM; i++)
            m[i] = rand_elem();
        k = $urandom_range(0, 7);
        if (k == 0)
        begin
            // copy a row: determinant exactly zero
            for (int c = 0; c < 3; c++)
                m[6 + c] = m[c];
        end
        else if (k == 1)
        begin
            for (int i = 0; i < NUM_ELEM; i++)
                if (i % 4 != 0)
                    m[i] = elem_t'($signed($urandom_range(0, 255)) - 128);
        end
        return m;
    endfunction

    task automatic idle_cycles();
        repeat ($urandom_range(1, 12)) @(posedge clk);
    endtask

    // Send one matrix; optional typed-in expectation overrides the predictor.
    // tvalid stays high after the transfer so that the next matrix can follow
    // back to back; drop it before idling and before a threshold write.
    task automatic send_matrix(input mat_t m, input bit has_exp, input normal_t exp_n);
        normal_t exp_item;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            idle_cycles();
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pack_matrix(m);
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        exp_item = has_exp ? exp_n : predict_normal(m);
        pending_normals.insert(pending_normals.size(), exp_item);
    endtask

    task automatic write_threshold(input logic [THR_WIDTH-1:0] v);
        s_tvalid <= 1'b0;
        while (pending_normals.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        threshold = v;
    endtask

    // Result side: random stalls, compare each transfer with the oldest entry
    always @(posedge clk)
    begin
        normal_t e;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_normals.size() == 0)
            begin
                $display("%0t: unexpected result %h sing %b", $time, m_tdata, m_tuser);
                errors++;
            end
            else
            begin
                e = pending_normals.pop_front();
                for (int i = 0; i < NUM_ELEM; i++)
                    if (m_tdata[i*EW +: EW] !== e.data[i*EW +: EW])
                    begin
                        $display("%0t: n%0d%0d expected %h actual %h", $time, i / 3, i % 3,
                                 e.data[i*EW +: EW], m_tdata[i*EW +: EW]);
                        errors++;
                    end
                if (m_tuser[0] !== e.sing)
                begin
                    $display("%0t: singular expected %b actual %b", $time, e.sing, m_tuser);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        sink_on = 1'b1;
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!quiet && $urandom_range(0, 4) == 0)
            begin
                m_tready <= 1'b0;
                idle_cycles();
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clk);
        end
    end

    typedef struct {
        mat_t    m;
        bit      has_exp;
        normal_t exp_n;
    } vector_t;

    initial
    begin
        vector_t       vec [NDIR];
        mat_t          z;
        normal_t       zero_sing;
        logic [DW-1:0] ident;
        int            wait_cnt;
        errors = 0;
        quiet  = 1'b0;
        threshold = THR_RESET;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        for (int i = 0; i < NUM_ELEM; i++)
            z[i] = '0;
        zero_sing.data = '0;
        zero_sing.sing = 1'b1;
        ident = '0;
        for (int i = 0; i < NUM_ELEM; i += 4)
            ident[i*EW +: EW] = 32'h0100_0000;
        foreach (vec[k])
        begin
            vec[k].m = z;
            vec[k].has_exp = 1'b0;
        end
        // all zero: singular
        vec[0].has_exp = 1'b1;
        vec[0].exp_n   = zero_sing;
        // identity
        vec[1].m[0] = 32'h0100_0000; vec[1].m[4] = 32'h0100_0000;
        vec[1].m[8] = 32'h0100_0000;
        vec[1].has_exp = 1'b1;
        vec[1].exp_n.data = ident;
        vec[1].exp_n.sing = 1'b0;
        // scaled diagonal, negative diagonal
        vec[2].m[0] = 32'h0200_0000; vec[2].m[4] = 32'h0080_0000;
        vec[2].m[8] = 32'h0400_0000;
        vec[3].m[0] = -32'sh0100_0000; vec[3].m[4] = 32'h0100_0000;
        vec[3].m[8] = -32'sh0300_0000;
        // tiny diagonal: determinant below the default threshold, so singular
        vec[4].m[0] = 32'h0000_0100; vec[4].m[4] = 32'h0000_0100;
        vec[4].m[8] = 32'h0000_0100;
        vec[5].m = vec[4].m; vec[5].m[0] = -32'sh0000_0100;
        // all extremes
        for (int i = 0; i < NUM_ELEM; i++)
        begin
            vec[6].m[i] = 32'sh7FFF_FFFF;
            vec[7].m[i] = (i % 2) ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            vec[8].m[i] = (i % 4 == 0) ? 32'sh8000_0000 : 32'sh0000_0000;
            vec[9].m[i] = (i % 4 == 0) ? 32'sh7FFF_FFFF : -32'sh0000_0001;
        end
        vec[6].has_exp = 1'b1;
        vec[6].exp_n   = zero_sing;
        // small determinants, still above the default threshold: diag 1, 1, small
        vec[10].m[0] = 32'h0100_0000; vec[10].m[4] = 32'h0100_0000;
        vec[10].m[8] = 32'h0000_0001;
        vec[11].m = vec[10].m; vec[11].m[8] = 32'h0000_00AB;
        vec[12].m = vec[10].m; vec[12].m[8] = 32'h0000_00AC;
        vec[13].m[1] = 32'h0100_0000; vec[13].m[5] = 32'h0100_0000;
        vec[13].m[6] = 32'h0100_0000;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (vec[k])
            send_matrix(vec[k].m, vec[k].has_exp, vec[k].exp_n);

        // threshold sweep, extremes included; zero determinant stays singular
        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0: write_threshold('0);
                1: write_threshold('1);
                2: write_threshold(32'h0000_1000);
                3: write_threshold($urandom);
                default: write_threshold(THR_RESET);
            endcase
            send_matrix(vec[0].m, 1'b1, zero_sing);
            send_matrix(vec[10].m, 1'b0, zero_sing);
            for (int n = 0; n < NRAND / 5; n++)
            begin
                if (phase == 4 && n > NRAND / 10)
                    quiet = 1'b1;
                send_matrix(rand_matrix(), 1'b0, zero_sing);
            end
        end
        s_tvalid <= 1'b0;

        wait_cnt = 0;
        while (pending_normals.size() != 0 && wait_cnt < 100000)
        begin
            @(posedge clk);
            wait_cnt++;
        end
        repeat (LATENCY + 4) @(posedge clk);
        if (errors == 0 && pending_normals.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
